[hdl/chained_hash_set_macros.svh]
// Assertion macros used by the chained hash set RTL.
`ifndef CHAINED_HASH_SET_MACROS_SVH
`define CHAINED_HASH_SET_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication, ignored while in reset
`define CHS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, ignored while in reset
`define CHS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CHS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CHS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[hdl/chs_pkg.sv]
// Types and constants for the chained hash set.
`default_nettype none

package chs_pkg;

    localparam int KEY_W   = 32;
    localparam int TOTAL_W = 9;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_HEAD,
        S_HLOAD,
        S_WALK,
        S_CMP,
        S_DECIDE,
        S_POP,
        S_ALLOC
    } t_state;

endpackage

`default_nettype wire

[hdl/chs_bucket_hash.sv]
// Bucket hash unit: key magnitude modulo BUCKETS by reciprocal multiplication.
`default_nettype none

module chs_bucket_hash #(
    parameter int BUCKETS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_load,
    input  wire logic [chs_pkg::KEY_W-1:0]     i_mag,
    output logic                               o_done,
    output logic [$clog2(BUCKETS)-1:0]         o_rem
);
    import chs_pkg::*;

    localparam int RW = $clog2(BUCKETS);
    localparam int MW = KEY_W + 1;
    localparam int PW = KEY_W + MW;
    // floor(2^(KEY_W+RW) / BUCKETS) + 1 gives the exact quotient for any magnitude
    localparam logic [63:0]      SCALE = 64'd1 << (KEY_W + RW);
    localparam logic [MW-1:0]    RECIP = MW'(SCALE / 64'(BUCKETS) + 64'd1);
    localparam logic [KEY_W-1:0] DIV   = KEY_W'(BUCKETS);

    logic             r_mul,  n_mul;
    logic             r_fold, n_fold;
    logic             r_done, n_done;
    logic [KEY_W-1:0] r_mag,  n_mag;
    logic [PW-1:0]    r_prod, n_prod;
    logic [RW-1:0]    r_rem,  n_rem;
    logic [KEY_W-1:0] quot;
    logic [KEY_W-1:0] back;

    // quotient from the registered product, then multiplied back
    assign quot = KEY_W'(r_prod >> (KEY_W + RW));
    assign back = quot * DIV;

    // sequencer: load, multiply, fold back, one-cycle done pulse
    always_comb begin
        n_mul  = 1'b0;
        n_fold = 1'b0;
        n_done = 1'b0;
        n_mag  = r_mag;
        n_prod = r_prod;
        n_rem  = r_rem;
        if (i_load) begin
            n_mul = 1'b1;
            n_mag = i_mag;
        end
        if (r_mul) begin
            n_prod = PW'(r_mag) * PW'(RECIP);
            n_fold = 1'b1;
        end
        if (r_fold) begin
            n_rem  = RW'(r_mag - back);
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul  <= 1'b0;
            r_fold <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_mul  <= n_mul;
            r_fold <= n_fold;
            r_done <= n_done;
        end
        r_mag  <= n_mag;
        r_prod <= n_prod;
        r_rem  <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

[hdl/chained_hash_set.sv]
// Top level of the chained hash set: sequencer, bucket, node and free-stack memories.
// Usage:
//   Command channel: a word (i_op, i_key) is taken at a rising edge with start high
//   and busy low. busy stays high until the result has been produced.
//   Result channel: o_done is high for exactly one cycle with o_ok, o_pool_full and
//   o_element_total; the receiver cannot stall, so it must take the word then.
//   A new command may be issued in the same cycle as the o_done pulse.
// Sequencing: the bucket comes from a remainder unit that multiplies the key magnitude
//   by a fixed reciprocal and folds the quotient back. The chain is then walked
//   through the node memory with its registered read port, node by node; an add
//   that reuses a removed node also reads the free stack first (S_POP, S_ALLOC).
//   Commands never overlap: a new one is taken only once the last has finished.
// Reset: a clearing pass writes every bucket head empty, one a cycle, with busy
//   high. Node memories are never cleared; a node is taken from the stack of removed
//   nodes while it holds any, and otherwise from a fresh-node counter.
`default_nettype none
`include "chained_hash_set_macros.svh"

module chained_hash_set #(
    parameter int BUCKETS = 16,
    parameter int NODES   = 256
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [1:0]                       i_op,
    input  wire logic signed [chs_pkg::KEY_W-1:0] i_key,
    output logic                                  o_done,
    output logic                                  o_ok,
    output logic                                  o_pool_full,
    output logic [chs_pkg::TOTAL_W-1:0]           o_element_total
);
    import chs_pkg::*;

    localparam int IW = $clog2(NODES);
    localparam int LW = IW + 1;
    localparam int CW = $clog2(NODES + 1);
    localparam int BW = $clog2(BUCKETS);
    localparam int NW = KEY_W + LW;
    localparam logic [LW-1:0] LINK_NULL = {1'b1, {IW{1'b0}}};

    // memories
    logic [LW-1:0] heads  [BUCKETS];
    logic [NW-1:0] nodes  [NODES];
    logic [IW-1:0] fstack [NODES];

    // control state
    t_state        r_state, n_state;
    logic [BW-1:0] r_clr,   n_clr;
    logic [CW-1:0] r_fresh, n_fresh;
    logic [CW-1:0] r_fsp,   n_fsp;
    logic [CW-1:0] r_count, n_count;
    logic          r_done,  n_done;
    logic          r_ok,    n_ok;
    logic          r_full,  n_full;

    // per-command datapath
    logic [1:0]       r_op,      n_op;
    logic [KEY_W-1:0] r_key,     n_key;
    logic [BW-1:0]    r_bucket,  n_bucket;
    logic [LW-1:0]    r_headv,   n_headv;
    logic [LW-1:0]    r_cur,     n_cur;
    logic [LW-1:0]    r_prev,    n_prev;
    logic [KEY_W-1:0] r_prevkey, n_prevkey;
    logic [LW-1:0]    r_hitlink, n_hitlink;
    logic [IW-1:0]    r_hit,     n_hit;
    logic             r_found,   n_found;

    // memory read data
    logic [LW-1:0] r_head_q;
    logic [NW-1:0] r_node_q;
    logic [IW-1:0] r_fs_q;

    // memory ports
    logic          head_we;
    logic [BW-1:0] head_wa;
    logic [LW-1:0] head_wd;
    logic          node_we;
    logic [IW-1:0] node_wa;
    logic [NW-1:0] node_wd;
    logic [IW-1:0] node_ra;
    logic          fs_we;

    logic             accept;
    logic             h_done;
    logic [BW-1:0]    h_rem;
    logic [KEY_W-1:0] key_mag;
    logic [KEY_W-1:0] q_key;
    logic [LW-1:0]    q_link;
    logic [IW-1:0]    new_node;

    assign accept  = start && (r_state == S_IDLE);
    assign key_mag = i_key[KEY_W-1] ? (KEY_W'(0) - KEY_W'(i_key)) : KEY_W'(i_key);
    assign q_key   = r_node_q[NW-1 -: KEY_W];
    assign q_link  = r_node_q[LW-1:0];

    chs_bucket_hash #(
        .BUCKETS (BUCKETS)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_mag   (key_mag),
        .o_done  (h_done),
        .o_rem   (h_rem)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:  if (r_clr == BW'(BUCKETS-1)) n_state = S_IDLE;
            S_IDLE:   if (start) n_state = S_HASH;
            S_HASH:   if (h_done) n_state = S_HEAD;
            S_HEAD:   n_state = S_HLOAD;
            S_HLOAD:  n_state = S_WALK;
            S_WALK:   n_state = r_cur[IW] ? S_DECIDE : S_CMP;
            S_CMP:    n_state = (q_key == r_key) ? S_DECIDE : S_WALK;
            S_DECIDE: begin
                if (r_op == OP_ADD && !r_found && r_count != CW'(NODES)
                        && r_fsp != '0) begin
                    n_state = S_POP;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_POP:    n_state = S_ALLOC;
            S_ALLOC:  n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath, memory writes and result word
    always_comb begin
        n_clr     = r_clr;
        n_fresh   = r_fresh;
        n_fsp     = r_fsp;
        n_count   = r_count;
        n_done    = 1'b0;
        n_ok      = 1'b0;
        n_full    = 1'b0;
        n_op      = r_op;
        n_key     = r_key;
        n_bucket  = r_bucket;
        n_headv   = r_headv;
        n_cur     = r_cur;
        n_prev    = r_prev;
        n_prevkey = r_prevkey;
        n_hitlink = r_hitlink;
        n_hit     = r_hit;
        n_found   = r_found;
        head_we   = 1'b0;
        head_wa   = r_bucket;
        head_wd   = LINK_NULL;
        node_we   = 1'b0;
        node_wa   = r_hit;
        node_wd   = {r_key, r_headv};
        node_ra   = r_cur[IW-1:0];
        fs_we     = 1'b0;
        new_node  = r_fresh[IW-1:0];
        case (r_state)
            S_CLEAR: begin
                head_we = 1'b1;
                head_wa = r_clr;
                n_clr   = r_clr + 1'b1;
            end
            S_IDLE: begin
                if (start) begin
                    n_op    = i_op;
                    n_key   = KEY_W'(i_key);
                    n_found = 1'b0;
                end
            end
            S_HASH: begin
                if (h_done) n_bucket = h_rem;
            end
            S_HLOAD: begin
                n_headv = r_head_q;
                n_cur   = r_head_q;
                n_prev  = LINK_NULL;
            end
            S_CMP: begin
                if (q_key == r_key) begin
                    n_found   = 1'b1;
                    n_hit     = r_cur[IW-1:0];
                    n_hitlink = q_link;
                end else begin
                    n_prev    = r_cur;
                    n_prevkey = q_key;
                    n_cur     = q_link;
                end
            end
            S_DECIDE: begin
                n_done = 1'b1;
                case (r_op)
                    OP_ADD: begin
                        if (!r_found) begin
                            if (r_count == CW'(NODES)) begin
                                n_full = 1'b1;
                            end else if (r_fsp != '0) begin
                                // reuse a removed node: read the stack first
                                n_done = 1'b0;
                            end else begin
                                node_we = 1'b1;
                                node_wa = new_node;
                                head_we = 1'b1;
                                head_wd = {1'b0, new_node};
                                n_fresh = r_fresh + 1'b1;
                                n_count = r_count + 1'b1;
                                n_ok    = 1'b1;
                            end
                        end
                    end
                    OP_REMOVE: begin
                        if (r_found) begin
                            // unlink from predecessor or bucket head
                            if (r_prev[IW]) begin
                                head_we = 1'b1;
                                head_wd = r_hitlink;
                            end else begin
                                node_we = 1'b1;
                                node_wa = r_prev[IW-1:0];
                                node_wd = {r_prevkey, r_hitlink};
                            end
                            fs_we   = 1'b1;
                            n_fsp   = r_fsp + 1'b1;
                            n_count = r_count - 1'b1;
                            n_ok    = 1'b1;
                        end
                    end
                    OP_SEARCH: n_ok = r_found;
                    default:   n_ok = 1'b0;
                endcase
            end
            S_ALLOC: begin
                new_node = r_fs_q;
                node_we  = 1'b1;
                node_wa  = r_fs_q;
                head_we  = 1'b1;
                head_wd  = {1'b0, r_fs_q};
                n_fsp    = r_fsp - 1'b1;
                n_count  = r_count + 1'b1;
                n_ok     = 1'b1;
                n_done   = 1'b1;
            end
            default: ;
        endcase
    end

    // bucket head memory
    always_ff @(posedge i_clk) begin
        if (head_we) heads[head_wa] <= head_wd;
        r_head_q <= heads[r_bucket];
    end

    // node memory: key and link per node
    always_ff @(posedge i_clk) begin
        if (node_we) nodes[node_wa] <= node_wd;
        r_node_q <= nodes[node_ra];
    end

    // stack of removed nodes
    always_ff @(posedge i_clk) begin
        if (fs_we) fstack[r_fsp[IW-1:0]] <= r_hit;
        r_fs_q <= fstack[IW'(r_fsp - 1'b1)];
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_fresh <= '0;
            r_fsp   <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
            r_ok    <= 1'b0;
            r_full  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_fresh <= n_fresh;
            r_fsp   <= n_fsp;
            r_count <= n_count;
            r_done  <= n_done;
            r_ok    <= n_ok;
            r_full  <= n_full;
        end
        r_op      <= n_op;
        r_key     <= n_key;
        r_bucket  <= n_bucket;
        r_headv   <= n_headv;
        r_cur     <= n_cur;
        r_prev    <= n_prev;
        r_prevkey <= n_prevkey;
        r_hitlink <= n_hitlink;
        r_hit     <= n_hit;
        r_found   <= n_found;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_ok            = r_ok;
    assign o_pool_full     = r_full;
    assign o_element_total = TOTAL_W'(r_count);

    // checks
    `CHS_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_done, !busy)
    `CHS_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    `CHS_ASSERT_IMP(a_full_word, i_clk, i_rst_n, o_pool_full, o_done && !o_ok && r_count == CW'(NODES))
    `CHS_ASSERT_IMP(a_node_count, i_clk, i_rst_n, 1'b1, r_count == CW'(r_fresh - r_fsp))

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the chained hash set: directed table, then random sequences.
`timescale 1ns / 100ps

module tb_top;
    import chs_pkg::*;

    localparam int BUCKETS = 16;
    localparam int NODES   = 256;

    // op value with no meaning; the block answers it without touching the set
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic               ok;
        logic               pool_full;
        logic [TOTAL_W-1:0] total;
    } t_hash_reply;

    typedef struct {
        logic [1:0]        op;
        logic [KEY_W-1:0]  key;
        bit                typed;
        t_hash_reply       want;
    } t_stim_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic [1:0]               i_op = OP_SEARCH;
    logic signed [KEY_W-1:0]  i_key = '0;
    logic                     busy;
    logic                     o_done;
    logic                     o_ok;
    logic                     o_pool_full;
    logic [TOTAL_W-1:0]       o_element_total;

    // mirror of the hash table
    logic [8:0]       mir_head [BUCKETS];
    logic [KEY_W-1:0] mir_key  [NODES];
    logic [8:0]       mir_next [NODES];
    logic [7:0]       mir_free [NODES];
    logic [8:0]       mir_free_cnt;
    logic [8:0]       mir_size;

    t_hash_reply      awaited_replies [$];
    logic [KEY_W-1:0] added_keys [$];
    t_stim_row        dir_rows [$];
    int               n_fail = 0;
    bit               no_idle = 1'b0;

    chained_hash_set #(
        .BUCKETS(BUCKETS),
        .NODES  (NODES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_key          (i_key),
        .o_done         (o_done),
        .o_ok           (o_ok),
        .o_pool_full    (o_pool_full),
        .o_element_total(o_element_total)
    );

    always #5 i_clk = ~i_clk;

    // empty table, every node on the free stack
    task automatic mirror_reset();
        for (int i = 0; i < BUCKETS; i++) mir_head[i] = 9'(NODES);
        for (int i = 0; i < NODES; i++) mir_free[i] = 8'(i);
        mir_free_cnt = 9'(NODES);
        mir_size     = '0;
    endtask

    // apply one word to the mirror and return the reply it should give
    function automatic t_hash_reply set_apply(logic [1:0] op, logic [KEY_W-1:0] key);
        t_hash_reply      r;
        logic [KEY_W-1:0] mag;
        int               b, cur, prv, hit, steps, n;
        r     = '0;
        mag   = key[KEY_W-1] ? (32'd0 - key) : key;
        b     = int'(mag % BUCKETS);
        cur   = int'(mir_head[b]);
        prv   = NODES;
        hit   = NODES;
        steps = 0;
        while (cur < NODES && steps < NODES) begin
            if (mir_key[cur] == key) begin
                hit = cur;
                break;
            end
            prv = cur;
            cur = int'(mir_next[cur]);
            steps++;
        end
        case (op)
            OP_ADD: begin
                if (hit == NODES) begin
                    if (mir_free_cnt == 0) begin
                        r.pool_full = 1'b1;
                    end else begin
                        mir_free_cnt = mir_free_cnt - 1;
                        n            = int'(mir_free[mir_free_cnt]);
                        mir_key[n]   = key;
                        mir_next[n]  = mir_head[b];
                        mir_head[b]  = 9'(n);
                        mir_size     = mir_size + 1;
                        r.ok         = 1'b1;
                    end
                end
            end
            OP_REMOVE: begin
                if (hit != NODES) begin
                    if (prv != NODES) mir_next[prv] = mir_next[hit];
                    else mir_head[b] = mir_next[hit];
                    mir_free[mir_free_cnt] = 8'(hit);
                    mir_free_cnt = mir_free_cnt + 1;
                    mir_size     = mir_size - 1;
                    r.ok         = 1'b1;
                end
            end
            OP_SEARCH: r.ok = (hit != NODES);
            default: ;
        endcase
        r.total = mir_size;
        return r;
    endfunction

    function automatic t_stim_row mk_row(logic [1:0] op, logic [KEY_W-1:0] key, bit typed,
                                         logic ok, logic full, int total);
        t_stim_row s;
        s.op   = op;
        s.key  = key;
        s.typed = typed;
        s.want = '{ok: ok, pool_full: full, total: TOTAL_W'(total)};
        return s;
    endfunction

    // present one word, hold it until taken, then idle at random
    task automatic issue_word(logic [1:0] op, logic [KEY_W-1:0] key, bit typed,
                              t_hash_reply want);
        t_hash_reply pred;
        int          gap;
        start <= 1'b1;
        i_op  <= op;
        i_key <= key;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        pred = set_apply(op, key);
        awaited_replies.push_back(typed ? want : pred);
        if (op == OP_ADD) begin
            added_keys.push_back(key);
            if (added_keys.size() > 64) void'(added_keys.pop_front());
        end
        gap = 0;
        if (!no_idle) begin
            if ($urandom_range(0, 99) < 8) gap = $urandom_range(1, 60);
            else while ($urandom_range(0, 99) < 31) gap++;
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // sender holds off until every reply is in
    task automatic wait_replies();
        start <= 1'b0;
        @(posedge i_clk);
        while (awaited_replies.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35 && added_keys.size() != 0)
            return added_keys[$urandom_range(0, added_keys.size() - 1)];
        if (r < 65) return 32'($signed($urandom_range(0, 80)) - 40);
        if (r < 75) begin
            case ($urandom_range(0, 5))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'hffff_ffff;
                3: return 32'h0000_0010;
                4: return 32'h8000_0010;
                default: return 32'h0;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return OP_ADD;
        if (r < 70) return OP_REMOVE;
        if (r < 95) return OP_SEARCH;
        return OP_UNUSED;
    endfunction

    // loose mix of all operations over a small key population
    task automatic run_mixed(int count);
        for (int i = 0; i < count; i++) issue_word(pick_op(), pick_key(), 1'b0, '0);
    endtask

    // add a run of distinct keys, enough to exhaust the pool
    task automatic run_fill(logic [KEY_W-1:0] base, int stride);
        logic [KEY_W-1:0] k;
        for (int i = 0; i < 280; i++) begin
            if ($urandom_range(0, 99) < 10) begin
                k = base + 32'($urandom_range(0, i) * stride);
                issue_word($urandom_range(0, 1) ? OP_ADD : OP_SEARCH, k, 1'b0, '0);
            end else begin
                issue_word(OP_ADD, base + 32'(i * stride), 1'b0, '0);
            end
        end
    endtask

    // take the same run out again, with some stray words mixed in
    task automatic run_drain(logic [KEY_W-1:0] base, int stride);
        logic [KEY_W-1:0] k;
        for (int i = 0; i < 280; i++) begin
            if ($urandom_range(0, 99) < 15) begin
                k = base + 32'($urandom_range(0, 279) * stride);
                issue_word(pick_op(), k, 1'b0, '0);
            end else begin
                issue_word(OP_REMOVE, base + 32'(i * stride), 1'b0, '0);
            end
        end
    endtask

    // reply checker
    always @(posedge i_clk) begin
        t_hash_reply exp_r;
        if (i_rst_n && o_done === 1'b1) begin
            if (awaited_replies.size() == 0) begin
                $error("o_done: reply with none outstanding");
                n_fail++;
            end else begin
                exp_r = awaited_replies.pop_front();
                if (o_ok !== exp_r.ok) begin
                    $error("o_ok: expected %0d, got %0d", exp_r.ok, o_ok);
                    n_fail++;
                end
                if (o_pool_full !== exp_r.pool_full) begin
                    $error("o_pool_full: expected %0d, got %0d", exp_r.pool_full, o_pool_full);
                    n_fail++;
                end
                if (o_element_total !== exp_r.total) begin
                    $error("o_element_total: expected %0d, got %0d",
                           exp_r.total, o_element_total);
                    n_fail++;
                end
            end
        end
    end

    // stimulus
    initial begin
        logic [KEY_W-1:0] base;
        mirror_reset();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty set, extremes, duplicates, chain head/middle/tail removal
        dir_rows.push_back(mk_row(OP_SEARCH, 32'h0,         1, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_REMOVE, 32'h0,         1, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_UNUSED, 32'h7,         1, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_ADD,    32'h0,         1, 1, 0, 1));
        dir_rows.push_back(mk_row(OP_ADD,    32'h0,         1, 0, 0, 1));
        dir_rows.push_back(mk_row(OP_ADD,    32'h8000_0000, 1, 1, 0, 2));
        dir_rows.push_back(mk_row(OP_ADD,    32'h7fff_ffff, 1, 1, 0, 3));
        dir_rows.push_back(mk_row(OP_ADD,    32'hffff_ffff, 1, 1, 0, 4));
        dir_rows.push_back(mk_row(OP_SEARCH, 32'h8000_0000, 1, 1, 0, 4));
        dir_rows.push_back(mk_row(OP_SEARCH, 32'h7fff_ffff, 1, 1, 0, 4));
        dir_rows.push_back(mk_row(OP_ADD,    32'h0000_0010, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_ADD,    32'hffff_fff0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_SEARCH, 32'h0000_0020, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_REMOVE, 32'h0000_0010, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_REMOVE, 32'hffff_fff0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_REMOVE, 32'h0,         0, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_SEARCH, 32'h0000_0010, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_ADD,    32'h0000_0010, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_UNUSED, 32'h8000_0000, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_REMOVE, 32'h8000_0000, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_REMOVE, 32'h8000_0000, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_SEARCH, 32'hffff_ffff, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_ADD,    32'h5555_5555, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_ADD,    32'haaaa_aaaa, 0, 0, 0, 0));
        foreach (dir_rows[i])
            issue_word(dir_rows[i].op, dir_rows[i].key, dir_rows[i].typed, dir_rows[i].want);
        wait_replies();

        // random: mixed traffic, pool exhaustion and recovery, long chains
        run_mixed(200);
        wait_replies();
        base = $urandom;
        run_fill(base, 1);
        run_mixed(60);
        run_drain(base, 1);
        wait_replies();
        no_idle = 1'b1;
        run_mixed(200);
        no_idle = 1'b0;
        base = $urandom;
        run_fill(base, 16);
        run_mixed(40);
        wait_replies();
        run_drain(base, 16);
        run_mixed(100);
        wait_replies();

        repeat (40) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("chained_hash_set test passed");
        end else begin
            $display("chained_hash_set test failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #50_000_000;
        $display("chained_hash_set test failed");
        $finish;
    end

endmodule
